// File: hdl/pmd_pkg.sv
// Shared types and constants for the plasma midpoint displacement block.
// Used by pmd_ctrl, pmd_dp and plasma_midpoint_displacement; no dependencies.
package pmd_pkg;

   // Fixed field widths
   localparam int GRID_BITS     = 20;   // signed height word, 16 fraction bits
   localparam int SAMPLE_BITS   = 17;
   localparam int CORNER_BITS   = 17;
   localparam int CFG_SIZE_BITS = 9;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;
   localparam int LEVEL_BITS    = 4;
   localparam int OUT_BITS      = 8;

   localparam int CFG_SIZE_RESET = 256;
   localparam int HALF_ONE       = 32768;
   localparam int FULL_ONE       = 65536;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 4'd15;

   // Sequencer step counts
   localparam logic [2:0] CORNER_LAST = 3'd3;
   localparam logic [2:0] READ_LAST   = 3'd3;
   localparam logic [2:0] WRITE_LAST  = 3'd4;
   localparam logic [2:0] PUSH_LAST   = 3'd3;

   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_STEP    = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_WIDTH   = 3'd0,
      CSR_GRID_HEIGHT  = 3'd1,
      CSR_CORNER_TL    = 3'd2,
      CSR_CORNER_TR    = 3'd3,
      CSR_CORNER_BL    = 3'd4,
      CSR_CORNER_BR    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CORNER,
      ST_QREAD,
      ST_CHECK,
      ST_GREAD,
      ST_GWAIT,
      ST_CALC,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_FINISHED,
      RSP_SKIP,
      RSP_DRAWN
   } rsp_kind_type;

   typedef struct packed {
      logic         start_restart;
      logic         start_step;
      logic         clr_wr;
      logic         corner_wr;
      logic         root_push;
      logic         q_pop;
      logic         g_rd;
      logic         calc;
      logic         g_wr;
      logic         q_push;
      logic [2:0]   idx;
      logic         rsp_fire;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic q_empty;
      logic skip;
      logic clr_last;
   } status_type;

endpackage

// File: hdl/plasma_midpoint_displacement.sv
// A restart clears the W x H grid area (W, H = latched grid size); the clear sweep
// writes one grid word per cycle. A subdivided rectangle takes four grid reads and
// five grid writes through the single grid port. The next item is taken in the strobe
// cycle. Results cannot be stalled. Reset is synchronous, active high: queue empty,
// registers at 256, 256, 0, 0, 0, 0; grid contents are cleared by restart, not by reset.
// Top level: CSR file plus pmd_ctrl and pmd_dp. Depends on pmd_pkg.
module plasma_midpoint_displacement
   import pmd_pkg::*;
#(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int QUEUE_DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_op,
   input  logic [SAMPLE_BITS-1:0]   req_random_sample,
   // result channel, one-cycle strobe
   output logic                     rsp_valid,
   output logic [OUT_BITS-1:0]      rsp_rect_x,
   output logic [OUT_BITS-1:0]      rsp_rect_y,
   output logic [OUT_BITS-1:0]      rsp_rect_w,
   output logic [OUT_BITS-1:0]      rsp_rect_h,
   output logic [OUT_BITS-1:0]      rsp_intensity,
   output logic                     rsp_drawn,
   output logic                     rsp_finished,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // ---------------- configuration registers
   // Grid size only takes effect at the next restart (latched in the datapath),
   // so a write never disturbs work in flight.
   logic [CFG_SIZE_BITS-1:0] grid_width_ff, grid_height_ff;
   logic [CORNER_BITS-1:0]   corner_tl_ff, corner_tr_ff, corner_bl_ff, corner_br_ff;
   logic                     csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= CFG_SIZE_BITS'(CFG_SIZE_RESET);
         grid_height_ff <= CFG_SIZE_BITS'(CFG_SIZE_RESET);
         corner_tl_ff   <= '0;
         corner_tr_ff   <= '0;
         corner_bl_ff   <= '0;
         corner_br_ff   <= '0;
      end else if (csr_xfer) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[CFG_SIZE_BITS-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[CFG_SIZE_BITS-1:0];
            CSR_CORNER_TL:   corner_tl_ff   <= csr_wdata;
            CSR_CORNER_TR:   corner_tr_ff   <= csr_wdata;
            CSR_CORNER_BL:   corner_bl_ff   <= csr_wdata;
            CSR_CORNER_BR:   corner_br_ff   <= csr_wdata;
            default:         grid_width_ff  <= grid_width_ff; // unmapped index: dropped
         endcase
      end
   end

   // ---------------- controller / datapath
   cmd_type    cmd;
   status_type stat;

   pmd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   pmd_dp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .cfg_width         (grid_width_ff),
      .cfg_height        (grid_height_ff),
      .corner_tl         (corner_tl_ff),
      .corner_tr         (corner_tr_ff),
      .corner_bl         (corner_bl_ff),
      .corner_br         (corner_br_ff),
      .req_random_sample (req_random_sample),
      .rsp_valid         (rsp_valid),
      .rsp_rect_x        (rsp_rect_x),
      .rsp_rect_y        (rsp_rect_y),
      .rsp_rect_w        (rsp_rect_w),
      .rsp_rect_h        (rsp_rect_h),
      .rsp_intensity     (rsp_intensity),
      .rsp_drawn         (rsp_drawn),
      .rsp_finished      (rsp_finished)
   );

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid)
      else $error("accepted transfer did not raise busy");
`endif

endmodule

// File: hdl/pmd_ctrl.sv
// Sequencer for the plasma midpoint displacement block.
// Depends on pmd_pkg; drives pmd_dp through cmd_type, reads status_type.
module pmd_ctrl
   import pmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_op,
   input  status_type stat,
   output logic       busy,
   output cmd_type    cmd
);

   state_type    state_ff, state_in;
   logic [2:0]   step_ff, step_in;
   rsp_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 3'd0;
         kind_ff  <= RSP_ZERO;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         kind_ff  <= kind_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = 3'd0;
            if (start && req_op == OP_RESTART) begin
               state_in = ST_CLEAR;
               kind_in  = RSP_ZERO;
            end else if (start) begin
               if (stat.q_empty) begin
                  state_in = ST_RESP;
                  kind_in  = RSP_FINISHED;
               end else begin
                  state_in = ST_QREAD;
               end
            end
         end
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = ST_CORNER;
            end
         end
         ST_CORNER: begin
            if (step_ff == CORNER_LAST) begin
               state_in = ST_RESP;
               step_in  = 3'd0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_QREAD: state_in = ST_CHECK;
         ST_CHECK: begin
            step_in = 3'd0;
            if (stat.skip) begin
               state_in = ST_RESP;
               kind_in  = RSP_SKIP;
            end else begin
               state_in = ST_GREAD;
            end
         end
         ST_GREAD: begin
            if (step_ff == READ_LAST) begin
               state_in = ST_GWAIT;
               step_in  = 3'd0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_GWAIT: state_in = ST_CALC;
         ST_CALC: begin
            state_in = ST_WRITE;
            step_in  = 3'd0;
         end
         ST_WRITE: begin
            if (step_ff == WRITE_LAST) begin
               state_in = ST_RESP;
               step_in  = 3'd0;
               kind_in  = RSP_DRAWN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.idx      = step_ff;
      cmd.rsp_kind = kind_ff;
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy              = 1'b0;
            cmd.start_restart = start && req_op == OP_RESTART;
            cmd.start_step    = start && req_op == OP_STEP;
         end
         ST_CLEAR:  cmd.clr_wr = 1'b1;
         ST_CORNER: begin
            cmd.corner_wr = 1'b1;
            cmd.root_push = step_ff == 3'd0;
         end
         ST_QREAD:  cmd.q_pop = 1'b1;
         ST_CHECK:  cmd.idx = 3'd0;
         ST_GREAD:  cmd.g_rd = 1'b1;
         ST_GWAIT:  cmd.idx = 3'd0;
         ST_CALC:   cmd.calc = 1'b1;
         ST_WRITE: begin
            cmd.g_wr   = 1'b1;
            cmd.q_push = step_ff <= PUSH_LAST;
         end
         ST_RESP:   cmd.rsp_fire = 1'b1;
         default:   cmd = '0;
      endcase
   end

`ifndef SYNTH
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GREAD || state_ff == ST_CORNER) |-> step_ff <= READ_LAST)
      else $error("step counter out of range in read/corner sweep");
   a_fire_once: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire |=> !cmd.rsp_fire && state_ff == ST_IDLE)
      else $error("response fired twice");
`endif

endmodule

// File: hdl/pmd_dp.sv
// Datapath: height grid memory, area queue memory, averaging and displacement.
// Depends on pmd_pkg; commanded by pmd_ctrl.
module pmd_dp
   import pmd_pkg::*;
#(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int QUEUE_DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               stat,
   input  logic [CFG_SIZE_BITS-1:0] cfg_width,
   input  logic [CFG_SIZE_BITS-1:0] cfg_height,
   input  logic [CORNER_BITS-1:0]   corner_tl,
   input  logic [CORNER_BITS-1:0]   corner_tr,
   input  logic [CORNER_BITS-1:0]   corner_bl,
   input  logic [CORNER_BITS-1:0]   corner_br,
   input  logic [SAMPLE_BITS-1:0]   req_random_sample,
   output logic                     rsp_valid,
   output logic [OUT_BITS-1:0]      rsp_rect_x,
   output logic [OUT_BITS-1:0]      rsp_rect_y,
   output logic [OUT_BITS-1:0]      rsp_rect_w,
   output logic [OUT_BITS-1:0]      rsp_rect_h,
   output logic [OUT_BITS-1:0]      rsp_intensity,
   output logic                     rsp_drawn,
   output logic                     rsp_finished
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int WW     = XW + 1;
   localparam int HW     = YW + 1;
   localparam int SWW    = (WW > CFG_SIZE_BITS) ? WW : CFG_SIZE_BITS;
   localparam int SHW    = (HW > CFG_SIZE_BITS) ? HW : CFG_SIZE_BITS;
   localparam int GDEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int GAW    = $clog2(GDEPTH);
   localparam int PW     = YW + WW;
   localparam int TW     = WW + HW;
   localparam int QAW    = $clog2(QUEUE_DEPTH);
   localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
   localparam int QEW    = 2 * XW + 2 * YW + LEVEL_BITS;
   localparam int Y2_LO  = LEVEL_BITS;
   localparam int X2_LO  = Y2_LO + YW;
   localparam int Y1_LO  = X2_LO + XW;
   localparam int X1_LO  = Y1_LO + YW;
   localparam int RESET_W = (CFG_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_SIZE_RESET;
   localparam int RESET_H = (CFG_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_SIZE_RESET;
   localparam logic signed [GRID_BITS-1:0] GRID_MAX = {1'b0, {(GRID_BITS-1){1'b1}}};
   localparam logic signed [GRID_BITS-1:0] GRID_MIN = {1'b1, {(GRID_BITS-1){1'b0}}};

   // floor((a + b) / 2)
   function automatic logic signed [GRID_BITS-1:0] mean2(
      input logic signed [GRID_BITS-1:0] a,
      input logic signed [GRID_BITS-1:0] b
   );
      logic signed [GRID_BITS:0] s;
      s = {a[GRID_BITS-1], a} + {b[GRID_BITS-1], b};
      return s[GRID_BITS:1];
   endfunction

   // ---------------- grid size latched at restart
   logic [WW-1:0]  used_w_ff, used_w_in;
   logic [HW-1:0]  used_h_ff, used_h_in;
   logic [SWW-1:0] w_ext;
   logic [SHW-1:0] h_ext;
   logic [XW-1:0]  wm1;
   logic [YW-1:0]  hm1;

   assign w_ext = SWW'(cfg_width);
   assign h_ext = SHW'(cfg_height);

   always_comb begin
      if (w_ext < SWW'(2))                used_w_in = WW'(2);
      else if (w_ext > SWW'(MAX_WIDTH))   used_w_in = WW'(MAX_WIDTH);
      else                                used_w_in = WW'(w_ext);
      if (h_ext < SHW'(2))                used_h_in = HW'(2);
      else if (h_ext > SHW'(MAX_HEIGHT))  used_h_in = HW'(MAX_HEIGHT);
      else                                used_h_in = HW'(h_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_w_ff <= WW'(RESET_W);
         used_h_ff <= HW'(RESET_H);
      end else if (cmd.start_restart) begin
         used_w_ff <= used_w_in;
         used_h_ff <= used_h_in;
      end
   end

   assign wm1 = XW'(used_w_ff - WW'(1));
   assign hm1 = YW'(used_h_ff - HW'(1));

   // ---------------- clear sweep over the used area
   logic [GAW-1:0] clr_ff;
   logic [TW-1:0]  total;

   assign total = TW'(used_w_ff) * TW'(used_h_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.start_restart) clr_ff <= '0;
      else if (cmd.clr_wr)            clr_ff <= clr_ff + GAW'(1);
   end

   // ---------------- area queue
   logic [QEW-1:0] q_mem [QUEUE_DEPTH];
   logic [QEW-1:0] q_rd_ff;
   logic [QAW-1:0] q_head_ff, q_tail_ff;
   logic [QCW-1:0] q_count_ff;
   logic [QEW-1:0] q_entry;
   logic           q_push, q_full;

   logic [XW-1:0]         a_x1, a_x2, mx;
   logic [YW-1:0]         a_y1, a_y2, my;
   logic [LEVEL_BITS-1:0] a_lv, lv_next;
   logic [XW:0]           x_sum;
   logic [YW:0]           y_sum;
   logic [XW-1:0]         dw;
   logic [YW-1:0]         dh;

   assign a_x1 = q_rd_ff[X1_LO +: XW];
   assign a_y1 = q_rd_ff[Y1_LO +: YW];
   assign a_x2 = q_rd_ff[X2_LO +: XW];
   assign a_y2 = q_rd_ff[Y2_LO +: YW];
   assign a_lv = q_rd_ff[LEVEL_BITS-1:0];
   assign x_sum = {1'b0, a_x1} + {1'b0, a_x2};
   assign y_sum = {1'b0, a_y1} + {1'b0, a_y2};
   assign mx = x_sum[XW:1];
   assign my = y_sum[YW:1];
   assign dw = a_x2 - a_x1;
   assign dh = a_y2 - a_y1;
   assign lv_next = (a_lv == LEVEL_MAX) ? LEVEL_MAX : a_lv + 4'd1;

   assign q_push = cmd.q_push || cmd.root_push;
   assign q_full = q_count_ff == QCW'(QUEUE_DEPTH);

   always_comb begin
      if (cmd.root_push) begin
         q_entry = {XW'(0), YW'(0), wm1, hm1, LEVEL_BITS'(0)};
      end else begin
         case (cmd.idx[1:0])
            2'd0:    q_entry = {a_x1, a_y1, mx, my, lv_next};
            2'd1:    q_entry = {mx, a_y1, a_x2, my, lv_next};
            2'd2:    q_entry = {a_x1, my, mx, a_y2, lv_next};
            default: q_entry = {mx, my, a_x2, a_y2, lv_next};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_push && !q_full) q_mem[q_tail_ff] <= q_entry;
      if (cmd.q_pop)         q_rd_ff <= q_mem[q_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start_restart) begin
         q_head_ff  <= '0;
         q_tail_ff  <= '0;
         q_count_ff <= '0;
      end else if (cmd.q_pop) begin
         q_head_ff  <= (q_head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_head_ff + QAW'(1);
         q_count_ff <= q_count_ff - QCW'(1);
      end else if (q_push && !q_full) begin
         q_tail_ff  <= (q_tail_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : q_tail_ff + QAW'(1);
         q_count_ff <= q_count_ff + QCW'(1);
      end
   end

   // ---------------- height grid
   logic [GRID_BITS-1:0]        grid_mem [GDEPTH];
   logic signed [GRID_BITS-1:0] grid_rd_ff;
   logic signed [GRID_BITS-1:0] v_ff [4];
   logic signed [GRID_BITS-1:0] centre_ff, centre_in;
   logic signed [GRID_BITS-1:0] grid_wdata;
   logic                        rd_pend_ff;
   logic [1:0]                  rd_idx_ff;
   logic [XW-1:0]               gx;
   logic [YW-1:0]               gy;
   logic [PW-1:0]               grid_lin;
   logic [GAW-1:0]              grid_addr;
   logic                        grid_we;

   always_comb begin
      gx = '0;
      gy = '0;
      if (cmd.corner_wr) begin
         case (cmd.idx[1:0])
            2'd0:    begin gx = '0;   gy = '0;   end
            2'd1:    begin gx = wm1;  gy = '0;   end
            2'd2:    begin gx = '0;   gy = hm1;  end
            default: begin gx = wm1;  gy = hm1;  end
         endcase
      end else if (cmd.g_rd) begin
         case (cmd.idx[1:0])
            2'd0:    begin gx = a_x1; gy = a_y1; end
            2'd1:    begin gx = a_x2; gy = a_y1; end
            2'd2:    begin gx = a_x1; gy = a_y2; end
            default: begin gx = a_x2; gy = a_y2; end
         endcase
      end else begin
         case (cmd.idx)
            3'd0:    begin gx = mx;   gy = my;   end
            3'd1:    begin gx = mx;   gy = a_y1; end
            3'd2:    begin gx = mx;   gy = a_y2; end
            3'd3:    begin gx = a_x1; gy = my;   end
            default: begin gx = a_x2; gy = my;   end
         endcase
      end
   end

   // row-major cell index
   assign grid_lin  = PW'(gy) * PW'(used_w_ff) + PW'(gx);
   assign grid_addr = cmd.clr_wr ? clr_ff : GAW'(grid_lin);
   assign grid_we   = cmd.clr_wr || cmd.corner_wr || cmd.g_wr;

   always_comb begin
      grid_wdata = '0;
      if (cmd.corner_wr) begin
         case (cmd.idx[1:0])
            2'd0:    grid_wdata = GRID_BITS'(corner_tl);
            2'd1:    grid_wdata = GRID_BITS'(corner_tr);
            2'd2:    grid_wdata = GRID_BITS'(corner_bl);
            default: grid_wdata = GRID_BITS'(corner_br);
         endcase
      end else if (cmd.g_wr) begin
         case (cmd.idx)
            3'd0:    grid_wdata = centre_ff;
            3'd1:    grid_wdata = mean2(v_ff[0], v_ff[1]);
            3'd2:    grid_wdata = mean2(v_ff[2], v_ff[3]);
            3'd3:    grid_wdata = mean2(v_ff[0], v_ff[2]);
            default: grid_wdata = mean2(v_ff[1], v_ff[3]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (grid_we)  grid_mem[grid_addr] <= grid_wdata;
      if (cmd.g_rd) grid_rd_ff <= grid_mem[grid_addr];
   end

   // read data lands in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else       rd_pend_ff <= cmd.g_rd;
      rd_idx_ff <= cmd.idx[1:0];
      if (rd_pend_ff) v_ff[rd_idx_ff] <= grid_rd_ff;
   end

   // ---------------- centre value
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic signed [GRID_BITS+1:0]   sum4;
   logic signed [GRID_BITS-1:0]   mean4;
   logic signed [SAMPLE_BITS:0]   disp, disp_sh;
   logic signed [GRID_BITS:0]     centre_raw;

   always_ff @(posedge clock) begin
      if (cmd.start_step) sample_ff <= req_random_sample;
   end

   assign sum4 = (GRID_BITS+2)'(v_ff[0]) + (GRID_BITS+2)'(v_ff[1])
               + (GRID_BITS+2)'(v_ff[2]) + (GRID_BITS+2)'(v_ff[3]);
   assign mean4 = sum4[GRID_BITS+1:2];
   assign disp = $signed({1'b0, sample_ff}) - (SAMPLE_BITS+1)'(HALF_ONE);
   assign disp_sh = disp >>> a_lv;
   assign centre_raw = (GRID_BITS+1)'(mean4) + (GRID_BITS+1)'(disp_sh);

   always_comb begin
      if (centre_raw[GRID_BITS] != centre_raw[GRID_BITS-1]) begin
         centre_in = centre_raw[GRID_BITS] ? GRID_MIN : GRID_MAX;
      end else begin
         centre_in = centre_raw[GRID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) centre_ff <= centre_in;
   end

   // ---------------- intensity: clamp to 0..1.0, times 255, truncate
   logic [CORNER_BITS-1:0]    c_clamp;
   logic [CORNER_BITS+7:0]    c_scaled;

   always_comb begin
      if (centre_ff[GRID_BITS-1])                      c_clamp = '0;
      else if (centre_ff > GRID_BITS'(FULL_ONE))       c_clamp = CORNER_BITS'(FULL_ONE);
      else                                             c_clamp = CORNER_BITS'(centre_ff);
   end

   assign c_scaled = {c_clamp, 8'd0} - (CORNER_BITS+8)'(c_clamp);

   // ---------------- response register
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] rect_x_ff, rect_y_ff, rect_w_ff, rect_h_ff, intensity_ff;
   logic                drawn_ff, finished_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.rsp_fire;
      if (cmd.rsp_fire) begin
         rect_x_ff    <= '0;
         rect_y_ff    <= '0;
         rect_w_ff    <= '0;
         rect_h_ff    <= '0;
         intensity_ff <= '0;
         drawn_ff     <= 1'b0;
         finished_ff  <= 1'b0;
         case (cmd.rsp_kind)
            RSP_FINISHED: finished_ff <= 1'b1;
            RSP_SKIP: begin
               rect_x_ff <= OUT_BITS'(a_x1);
               rect_y_ff <= OUT_BITS'(a_y1);
               rect_w_ff <= OUT_BITS'(dw);
               rect_h_ff <= OUT_BITS'(dh);
            end
            RSP_DRAWN: begin
               rect_x_ff    <= OUT_BITS'(a_x1);
               rect_y_ff    <= OUT_BITS'(a_y1);
               rect_w_ff    <= OUT_BITS'(dw);
               rect_h_ff    <= OUT_BITS'(dh);
               intensity_ff <= c_scaled[23:16];
               drawn_ff     <= 1'b1;
            end
            default: drawn_ff <= 1'b0;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rect_x    = rect_x_ff;
   assign rsp_rect_y    = rect_y_ff;
   assign rsp_rect_w    = rect_w_ff;
   assign rsp_rect_h    = rect_h_ff;
   assign rsp_intensity = intensity_ff;
   assign rsp_drawn     = drawn_ff;
   assign rsp_finished  = finished_ff;

   // ---------------- status
   assign stat.q_empty  = q_count_ff == '0;
   assign stat.skip     = dw <= XW'(1) && dh <= YW'(1);
   assign stat.clr_last = TW'(clr_ff) == total - TW'(1);

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.q_pop |-> q_count_ff != '0)
      else $error("pop from empty area queue");
   a_clear_in_area: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> TW'(clr_ff) < total)
      else $error("clear sweep ran past used area");
`endif

endmodule

// File: tb/sv/tb_plasma_midpoint_displacement.sv
// Self-checking testbench for plasma_midpoint_displacement: directed rows, then random
// restart/step runs, scored against an in-bench model of the height grid and area queue;
// typed directed rows use fixed results. Depends on pmd_pkg and plasma_midpoint_displacement.
module tb_plasma_midpoint_displacement;
   import pmd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W       = 256;
   localparam int MAX_H       = 256;
   localparam int QDEPTH      = 65536;
   localparam int GRID_CELLS  = MAX_W * MAX_H;
   localparam int ITEM_TARGET = 1650;
   // The slowest legal run holds two full 256x256 clears plus small-grid phases; the limit
   // is many times its length.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int END_SETTLE  = 40;
   // Clamped grid area cap for random phases, keeps clear sweeps short
   localparam int AREA_CAP    = 1700;
   localparam int DRAIN_AREA  = 64;

   localparam longint GRID_TOP    = (longint'(1) <<< (GRID_BITS - 1)) - 1;
   localparam longint GRID_BOTTOM = -(longint'(1) <<< (GRID_BITS - 1));

   // Indexes past the register file: writes must be ignored
   localparam logic [CSR_IDX_BITS-1:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] SPARE_INDEX_HI = 3'd7;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = {SAMPLE_BITS{1'b1}};

   typedef struct packed {
      logic [OUT_BITS-1:0] rect_x;
      logic [OUT_BITS-1:0] rect_y;
      logic [OUT_BITS-1:0] rect_w;
      logic [OUT_BITS-1:0] rect_h;
      logic [OUT_BITS-1:0] intensity;
      logic                drawn;
      logic                finished;
   } plasma_rsp_t;

   typedef struct packed {
      logic [15:0]           x1;
      logic [15:0]           y1;
      logic [15:0]           x2;
      logic [15:0]           y2;
      logic [LEVEL_BITS-1:0] level;
   } area_t;

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e                kind;
      logic                     op;
      logic [SAMPLE_BITS-1:0]   smp;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] data;
      bit                       typed;
      plasma_rsp_t              want;
   } stim_row_t;

   // DUT connections; the bench-driven ones are known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_op = OP_RESTART;
   logic [SAMPLE_BITS-1:0]   req_random_sample = '0;
   logic                     rsp_valid;
   logic [OUT_BITS-1:0]      rsp_rect_x;
   logic [OUT_BITS-1:0]      rsp_rect_y;
   logic [OUT_BITS-1:0]      rsp_rect_w;
   logic [OUT_BITS-1:0]      rsp_rect_h;
   logic [OUT_BITS-1:0]      rsp_intensity;
   logic                     rsp_drawn;
   logic                     rsp_finished;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Model state: height map, pending rectangle FIFO, register shadow, latched size
   int                       height_map [GRID_CELLS];
   area_t                    pending_areas [$];
   logic [CSR_DATA_BITS-1:0] csr_shadow [0:5];
   int unsigned              span_w;
   int unsigned              span_h;

   plasma_rsp_t              expected_rsps [$];
   stim_row_t                directed_rows [$];
   int                       items_sent = 0;
   int                       rsp_seen   = 0;
   int                       mismatches = 0;
   int                       cycles     = 0;

   plasma_midpoint_displacement #(
      .MAX_WIDTH   (MAX_W),
      .MAX_HEIGHT  (MAX_H),
      .QUEUE_DEPTH (QDEPTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_random_sample (req_random_sample),
      .rsp_valid         (rsp_valid),
      .rsp_rect_x        (rsp_rect_x),
      .rsp_rect_y        (rsp_rect_y),
      .rsp_rect_w        (rsp_rect_w),
      .rsp_rect_h        (rsp_rect_h),
      .rsp_intensity     (rsp_intensity),
      .rsp_drawn         (rsp_drawn),
      .rsp_finished      (rsp_finished),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Model of the block
   // ---------------------------------------------------------------------------------

   // Size registers are clamped to 2..max when latched at restart
   function automatic int unsigned fit_span(input logic [CFG_SIZE_BITS-1:0] v,
                                            input int unsigned hi);
      if (v < 2) return 2;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int unsigned map_index(input int unsigned x, input int unsigned y);
      int unsigned i;
      i = y * span_w + x;
      return (i < GRID_CELLS) ? i : 0;
   endfunction

   function automatic int grid_fetch(input int unsigned x, input int unsigned y);
      return height_map[map_index(x, y)];
   endfunction

   // Every grid write saturates to the signed 20-bit range
   function automatic void grid_put(input int unsigned x, input int unsigned y,
                                    input longint v);
      if (v > GRID_TOP) v = GRID_TOP;
      if (v < GRID_BOTTOM) v = GRID_BOTTOM;
      height_map[map_index(x, y)] = int'(v);
   endfunction

   // Push to a full FIFO is dropped
   function automatic void queue_area(input int unsigned x1, input int unsigned y1,
                                      input int unsigned x2, input int unsigned y2,
                                      input logic [LEVEL_BITS-1:0] lv);
      area_t a;
      if (pending_areas.size() >= QDEPTH) return;
      a.x1 = x1;
      a.y1 = y1;
      a.x2 = x2;
      a.y2 = y2;
      a.level = lv;
      pending_areas.push_back(a);
   endfunction

   // Advance the model by one accepted command and return the result it produces
   function automatic plasma_rsp_t plasma_next(input logic op,
                                               input logic [SAMPLE_BITS-1:0] smp);
      plasma_rsp_t           r;
      area_t                 a;
      int unsigned           mx, my, k;
      longint                v1, v2, v3, v4, centre, lit;
      logic [LEVEL_BITS-1:0] lv;
      r = '0;
      if (op == OP_RESTART) begin
         span_w = fit_span(csr_shadow[CSR_GRID_WIDTH][CFG_SIZE_BITS-1:0], MAX_W);
         span_h = fit_span(csr_shadow[CSR_GRID_HEIGHT][CFG_SIZE_BITS-1:0], MAX_H);
         // only the in-use area is ever addressed, so clearing it is enough
         for (k = 0; k < span_w * span_h; k++) height_map[k] = 0;
         pending_areas.delete();
         grid_put(0, 0, csr_shadow[CSR_CORNER_TL]);
         grid_put(span_w - 1, 0, csr_shadow[CSR_CORNER_TR]);
         grid_put(0, span_h - 1, csr_shadow[CSR_CORNER_BL]);
         grid_put(span_w - 1, span_h - 1, csr_shadow[CSR_CORNER_BR]);
         queue_area(0, 0, span_w - 1, span_h - 1, '0);
         return r;
      end
      if (pending_areas.size() == 0) begin
         r.finished = 1'b1;
         return r;
      end
      a = pending_areas.pop_front();
      r.rect_x = a.x1[OUT_BITS-1:0];
      r.rect_y = a.y1[OUT_BITS-1:0];
      r.rect_w = a.x2 - a.x1;
      r.rect_h = a.y2 - a.y1;
      // single cell or less in both directions: report and drop
      if ((a.x2 - a.x1) <= 1 && (a.y2 - a.y1) <= 1) return r;
      mx = (a.x1 + a.x2) >> 1;
      my = (a.y1 + a.y2) >> 1;
      v1 = grid_fetch(a.x1, a.y1);
      v2 = grid_fetch(a.x2, a.y1);
      v3 = grid_fetch(a.x1, a.y2);
      v4 = grid_fetch(a.x2, a.y2);
      // arithmetic shifts on signed values round toward negative infinity
      centre = ((v1 + v2 + v3 + v4) >>> 2) + ((longint'(smp) - HALF_ONE) >>> a.level);
      if (centre > GRID_TOP) centre = GRID_TOP;
      if (centre < GRID_BOTTOM) centre = GRID_BOTTOM;
      grid_put(mx, my, centre);
      grid_put(mx, a.y1, (v1 + v2) >>> 1);
      grid_put(mx, a.y2, (v3 + v4) >>> 1);
      grid_put(a.x1, my, (v1 + v3) >>> 1);
      grid_put(a.x2, my, (v2 + v4) >>> 1);
      lit = (centre < 0) ? 0 : ((centre > FULL_ONE) ? FULL_ONE : centre);
      r.intensity = (lit * 255) >>> 16;
      r.drawn = 1'b1;
      lv = (a.level == LEVEL_MAX) ? LEVEL_MAX : a.level + 1'b1;
      queue_area(a.x1, a.y1, mx, my, lv);
      queue_area(mx, a.y1, a.x2, my, lv);
      queue_area(a.x1, my, mx, a.y2, lv);
      queue_area(mx, my, a.x2, a.y2, lv);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic plasma_rsp_t mk_rsp(input int x, input int y, input int w, input int h,
                                          input int lit, input bit drawn, input bit fin);
      plasma_rsp_t r;
      r.rect_x = x;
      r.rect_y = y;
      r.rect_w = w;
      r.rect_h = h;
      r.intensity = lit;
      r.drawn = drawn;
      r.finished = fin;
      return r;
   endfunction

   function automatic void add_cmd(input logic op, input logic [SAMPLE_BITS-1:0] smp);
      stim_row_t row;
      row.kind = ROW_CMD;
      row.op = op;
      row.smp = smp;
      row.idx = '0;
      row.data = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_fixed(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                                     input plasma_rsp_t want);
      stim_row_t row;
      row.kind = ROW_CMD;
      row.op = op;
      row.smp = smp;
      row.idx = '0;
      row.data = '0;
      row.typed = 1'b1;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_BITS-1:0] idx,
                                   input logic [CSR_DATA_BITS-1:0] data);
      stim_row_t row;
      row.kind = ROW_CSR;
      row.op = OP_RESTART;
      row.smp = '0;
      row.idx = idx;
      row.data = data;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   // Idle gaps are suppressed for one long stretch of the random part
   function automatic bit quiet_stretch();
      return (items_sent >= 600 && items_sent < 900);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return SAMPLE_TOP;
      if (r < 25) return FULL_ONE;
      if (r < 30) return HALF_ONE;
      return $urandom_range(0, SAMPLE_TOP);
   endfunction

   function automatic logic [CORNER_BITS-1:0] pick_corner();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return '0;
      if (r < 40) return FULL_ONE;
      if (r < 50) return {CORNER_BITS{1'b1}};
      return $urandom_range(0, {CORNER_BITS{1'b1}});
   endfunction

   // Mostly small grids; a few below 2 or above 256 to hit the clamp
   function automatic logic [CFG_SIZE_BITS-1:0] pick_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(2, 12);
      if (r < 85) return $urandom_range(13, 40);
      if (r < 95) return $urandom_range(0, 1);
      return $urandom_range(257, 511);
   endfunction

   // Stray bits above the 9-bit size field are masked off by the block
   function automatic logic [CSR_DATA_BITS-1:0] size_word(input logic [CFG_SIZE_BITS-1:0] v);
      logic [CSR_DATA_BITS-1:0] d;
      d = v;
      if ($urandom_range(0, 99) < 30)
         d[CSR_DATA_BITS-1:CFG_SIZE_BITS] = $urandom_range(0, 255);
      return d;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on result %0d, %s: got %0d, expected %0d",
                  rsp_seen, what, got, want);
   endtask

   // One command transfer; the model runs at the accepting edge
   task automatic issue_cmd(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                            input bit typed, input plasma_rsp_t want);
      plasma_rsp_t predicted;
      csr_valid <= 1'b0;
      if (!quiet_stretch() && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_random_sample <= smp;
      do @(posedge clock); while (busy);
      predicted = plasma_next(op, smp);
      expected_rsps.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Each command yields exactly one result, so an empty scoreboard means idle
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsps.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      if (!quiet_stretch() && $urandom_range(0, 99) < 25) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_CORNER_BR)
         csr_shadow[idx] = (idx <= CSR_GRID_HEIGHT) ? (data & {CFG_SIZE_BITS{1'b1}}) : data;
   endtask

   // ---------------------------------------------------------------------------------
   // Result checker: strobed results cannot be held off, sample every cycle
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      plasma_rsp_t want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", rsp_finished, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_rect_x !== want.rect_x) report_mismatch("rect_x", rsp_rect_x, want.rect_x);
            if (rsp_rect_y !== want.rect_y) report_mismatch("rect_y", rsp_rect_y, want.rect_y);
            if (rsp_rect_w !== want.rect_w) report_mismatch("rect_w", rsp_rect_w, want.rect_w);
            if (rsp_rect_h !== want.rect_h) report_mismatch("rect_h", rsp_rect_h, want.rect_h);
            if (rsp_intensity !== want.intensity)
               report_mismatch("intensity", rsp_intensity, want.intensity);
            if (rsp_drawn !== want.drawn) report_mismatch("drawn", rsp_drawn, want.drawn);
            if (rsp_finished !== want.finished)
               report_mismatch("finished", rsp_finished, want.finished);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("plasma_midpoint_displacement verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : main_seq
      logic [CFG_SIZE_BITS-1:0] w_raw, h_raw;
      int                       steps_left, n;
      bit                       drain_mode;

      // model after reset: registers at reset values, 256 x 256 latched, queue empty
      csr_shadow[CSR_GRID_WIDTH]  = CFG_SIZE_RESET;
      csr_shadow[CSR_GRID_HEIGHT] = CFG_SIZE_RESET;
      csr_shadow[CSR_CORNER_TL]   = '0;
      csr_shadow[CSR_CORNER_TR]   = '0;
      csr_shadow[CSR_CORNER_BL]   = '0;
      csr_shadow[CSR_CORNER_BR]   = '0;
      span_w = CFG_SIZE_RESET;
      span_h = CFG_SIZE_RESET;
      for (n = 0; n < GRID_CELLS; n++) height_map[n] = 0;

      // Directed rows. Typed results are the ones readable straight off the rules.
      // Step before any restart: queue empty, finished only.
      add_fixed(OP_STEP, '0, mk_rsp(0, 0, 0, 0, 0, 0, 1));
      // Restart at reset size 256 x 256, zero corners
      add_fixed(OP_RESTART, '0, mk_rsp(0, 0, 0, 0, 0, 0, 0));
      // Full area, top sample: intensity clamps to 1.0
      add_fixed(OP_STEP, SAMPLE_TOP, mk_rsp(0, 0, 255, 255, 255, 1, 0));
      add_cmd(OP_STEP, '0);
      add_cmd(OP_STEP, FULL_ONE);
      // Restart with rectangles still queued
      add_fixed(OP_RESTART, SAMPLE_TOP, mk_rsp(0, 0, 0, 0, 0, 0, 0));
      // Half sample: no displacement, centre zero
      add_fixed(OP_STEP, HALF_ONE, mk_rsp(0, 0, 255, 255, 0, 1, 0));
      // Sizes below the floor clamp to 2 x 2; corners at the top of their field
      add_csr(CSR_GRID_WIDTH, '0);
      add_csr(CSR_GRID_HEIGHT, 1);
      add_csr(CSR_CORNER_TL, {CORNER_BITS{1'b1}});
      add_csr(CSR_CORNER_TR, {CORNER_BITS{1'b1}});
      add_csr(CSR_CORNER_BL, {CORNER_BITS{1'b1}});
      add_csr(CSR_CORNER_BR, {CORNER_BITS{1'b1}});
      add_fixed(OP_RESTART, '0, mk_rsp(0, 0, 0, 0, 0, 0, 0));
      // 2 x 2 root is a skipped rectangle, then the queue runs dry
      add_fixed(OP_STEP, SAMPLE_TOP, mk_rsp(0, 0, 1, 1, 0, 0, 0));
      add_fixed(OP_STEP, '0, mk_rsp(0, 0, 0, 0, 0, 0, 1));
      // All-ones width clamps to 256; height with stray upper bits masks to 3
      add_csr(CSR_GRID_WIDTH, {CSR_DATA_BITS{1'b1}});
      add_csr(CSR_GRID_HEIGHT, 17'h1FE03);
      add_csr(CSR_CORNER_TL, FULL_ONE);
      add_csr(CSR_CORNER_TR, '0);
      add_csr(CSR_CORNER_BL, '0);
      add_csr(CSR_CORNER_BR, FULL_ONE);
      add_fixed(OP_RESTART, '0, mk_rsp(0, 0, 0, 0, 0, 0, 0));
      add_cmd(OP_STEP, FULL_ONE - 1);
      add_cmd(OP_STEP, 1);
      add_cmd(OP_STEP, 98304);
      // Narrowest width against the tallest height; spare indexes must be ignored
      add_csr(CSR_GRID_WIDTH, 2);
      add_csr(CSR_GRID_HEIGHT, MAX_H);
      add_csr(CSR_CORNER_TL, '0);
      add_csr(CSR_CORNER_TR, 12345);
      add_csr(CSR_CORNER_BL, 54321);
      add_csr(CSR_CORNER_BR, FULL_ONE);
      add_csr(SPARE_INDEX_LO, {CSR_DATA_BITS{1'b1}});
      add_csr(SPARE_INDEX_HI, 3);
      add_fixed(OP_RESTART, '0, mk_rsp(0, 0, 0, 0, 0, 0, 0));
      add_cmd(OP_STEP, '0);
      add_cmd(OP_STEP, SAMPLE_TOP);
      add_cmd(OP_STEP, HALF_ONE);
      add_cmd(OP_STEP, 1);
      add_cmd(OP_STEP, 100000);

      // single reset pulse
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            issue_cmd(directed_rows[i].op, directed_rows[i].smp,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases: reprogram while idle, restart, then a run of steps.
      // Small grids are sometimes stepped to exhaustion to reach finished.
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         w_raw = pick_span();
         h_raw = pick_span();
         if (fit_span(w_raw, MAX_W) * fit_span(h_raw, MAX_H) > AREA_CAP)
            h_raw = $urandom_range(2, 5);
         if ($urandom_range(0, 1)) begin
            csr_write(CSR_GRID_WIDTH, size_word(w_raw));
            csr_write(CSR_GRID_HEIGHT, size_word(h_raw));
         end else begin
            csr_write(CSR_GRID_HEIGHT, size_word(h_raw));
            csr_write(CSR_GRID_WIDTH, size_word(w_raw));
         end
         if ($urandom_range(0, 1)) csr_write(CSR_CORNER_TL, pick_corner());
         if ($urandom_range(0, 1)) csr_write(CSR_CORNER_TR, pick_corner());
         if ($urandom_range(0, 1)) csr_write(CSR_CORNER_BL, pick_corner());
         if ($urandom_range(0, 1)) csr_write(CSR_CORNER_BR, pick_corner());
         if ($urandom_range(0, 99) < 10)
            csr_write($urandom_range(0, 1) ? SPARE_INDEX_LO : SPARE_INDEX_HI,
                      $urandom_range(0, {CSR_DATA_BITS{1'b1}}));

         issue_cmd(OP_RESTART, pick_sample(), 1'b0, '0);
         drain_mode = (span_w * span_h <= DRAIN_AREA) && ($urandom_range(0, 99) < 30);
         steps_left = drain_mode ? $urandom_range(1, 3) : $urandom_range(1, 80);
         while (items_sent < ITEM_TARGET && steps_left > 0) begin
            // occasional restart in the middle of a run
            if ($urandom_range(0, 99) < 4) issue_cmd(OP_RESTART, pick_sample(), 1'b0, '0);
            else issue_cmd(OP_STEP, pick_sample(), 1'b0, '0);
            if (!(drain_mode && pending_areas.size() != 0)) steps_left--;
         end
      end

      // all commands out: wait for the last results, then a short quiet window
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("results still pending", expected_rsps.size(), 0);

      if (mismatches == 0)
         $display("plasma_midpoint_displacement verification clean");
      else
         $display("plasma_midpoint_displacement verification failed");
      $finish;
   end

endmodule
